/* hdl/hdv_pkg.sv */
// ----------------------------------------------------------------------------
// hdv_pkg
// Shared constants and types for the Hall drift velocity core: register
// indexes, reset values, velocity bounds and the divider beat format.
// ----------------------------------------------------------------------------
package hdv_pkg;

  localparam int NLANE       = 3;
  localparam int FRONT_DEPTH = 15;
  localparam int DIV_STEPS   = 48;

  // configuration register indexes
  localparam logic [2:0] REG_E_MOB  = 3'd0;
  localparam logic [2:0] REG_H_MOB  = 3'd1;
  localparam logic [2:0] REG_E_HALL = 3'd2;
  localparam logic [2:0] REG_H_HALL = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;

  localparam logic [31:0] RST_E_MOB  = 32'd16777216;
  localparam logic [31:0] RST_H_MOB  = 32'd1677722;
  localparam logic [15:0] RST_HALL   = 16'd4096;
  localparam logic [47:0] RST_THRESH = 48'd1;

  // largest positive velocity and magnitude of the most negative one
  localparam logic [47:0] VEL_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VEL_NEG_MAG = 48'h8000_0000_0000;

  typedef struct packed {
    logic [31:0] emob;
    logic [31:0] hmob;
    logic [15:0] ehall;
    logic [15:0] hhall;
    logic [47:0] thr;
  } cfg_t;

  // one lane of the long division: partial remainder, remaining dividend
  // bits that turn into quotient bits, overflow and result sign
  typedef struct packed {
    logic [63:0] rem;
    logic [47:0] nq;
    logic        ovf;
    logic        vn;
  } div_lane_t;

  typedef struct packed {
    logic [63:0]                d;
    div_lane_t [NLANE-1:0]      lane;
  } div_t;

endpackage

/* hdl/hdv_front.sv */
// ----------------------------------------------------------------------------
// hdv_front
// Arithmetic front end: Hall mobility, scaled field w, denominator D,
// numerators N and the rounded dividend M*|N|*2^8 + D/2, over 15 stages.
// ----------------------------------------------------------------------------
module hdv_front (
  input  logic                clk,
  input  logic                rst,
  input  hdv_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic signed [31:0]  efield_x,
  input  logic signed [31:0]  efield_y,
  input  logic signed [31:0]  efield_z,
  input  logic signed [23:0]  bfield_x,
  input  logic signed [23:0]  bfield_y,
  input  logic signed [23:0]  bfield_z,
  output logic                out_valid,
  input  logic                out_ready,
  output hdv_pkg::div_t       out_data
);

  logic [hdv_pkg::FRONT_DEPTH-1:0] v;
  logic [hdv_pkg::FRONT_DEPTH:0]   ld;

  logic signed [31:0] e_in [hdv_pkg::NLANE];
  logic        [23:0] b_in [hdv_pkg::NLANE];

  assign e_in[0] = efield_x;
  assign e_in[1] = efield_y;
  assign e_in[2] = efield_z;
  assign b_in[0] = bfield_x;
  assign b_in[1] = bfield_y;
  assign b_in[2] = bfield_z;

  // a stage loads when it is empty or the one after it moves on
  assign ld[hdv_pkg::FRONT_DEPTH] = out_ready;
  for (genvar s = 0; s < hdv_pkg::FRONT_DEPTH; s++) begin : g_ld
    assign ld[s] = ~v[s] | ld[s+1];
  end
  assign in_ready  = ld[0];
  assign out_valid = v[hdv_pkg::FRONT_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < hdv_pkg::FRONT_DEPTH; s++) begin
        if (ld[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // per-lane stage registers
  logic        [46:0]  r0_bsq  [hdv_pkg::NLANE];
  logic signed [31:0]  r0_e    [hdv_pkg::NLANE];
  logic        [23:0]  r0_babs [hdv_pkg::NLANE];
  logic                r0_bneg [hdv_pkg::NLANE];
  logic signed [31:0]  r1_e    [hdv_pkg::NLANE];
  logic        [23:0]  r1_babs [hdv_pkg::NLANE];
  logic                r1_bneg [hdv_pkg::NLANE];
  logic        [55:0]  r2_mb   [hdv_pkg::NLANE];
  logic signed [31:0]  r2_e    [hdv_pkg::NLANE];
  logic                r2_bneg [hdv_pkg::NLANE];
  logic        [30:0]  r3_wabs [hdv_pkg::NLANE];
  logic                r3_wneg [hdv_pkg::NLANE];
  logic signed [31:0]  r3_w    [hdv_pkg::NLANE];
  logic signed [31:0]  r3_e    [hdv_pkg::NLANE];
  logic        [61:0]  r4_wsq  [hdv_pkg::NLANE];
  logic signed [63:0]  r4_we   [hdv_pkg::NLANE];
  logic signed [63:0]  r4_c1   [hdv_pkg::NLANE];
  logic signed [63:0]  r4_c2   [hdv_pkg::NLANE];
  logic signed [31:0]  r4_e    [hdv_pkg::NLANE];
  logic        [30:0]  r4_wabs [hdv_pkg::NLANE];
  logic                r4_wneg [hdv_pkg::NLANE];
  logic signed [65:0]  r5_x    [hdv_pkg::NLANE];
  logic        [30:0]  r5_wabs [hdv_pkg::NLANE];
  logic                r5_wneg [hdv_pkg::NLANE];
  logic signed [65:0]  r6_x    [hdv_pkg::NLANE];
  logic        [30:0]  r6_wabs [hdv_pkg::NLANE];
  logic                r6_wneg [hdv_pkg::NLANE];
  logic        [54:0]  r7_wplo [hdv_pkg::NLANE];
  logic        [54:0]  r7_wphi [hdv_pkg::NLANE];
  logic                r7_sneg [hdv_pkg::NLANE];
  logic signed [65:0]  r7_x    [hdv_pkg::NLANE];
  logic        [78:0]  r8_wp   [hdv_pkg::NLANE];
  logic                r8_sneg [hdv_pkg::NLANE];
  logic signed [65:0]  r8_x    [hdv_pkg::NLANE];
  logic        [81:0]  r9_n    [hdv_pkg::NLANE];
  logic        [80:0]  r10_nabs[hdv_pkg::NLANE];
  logic                r10_vn  [hdv_pkg::NLANE];
  logic        [63:0]  r11_m0  [hdv_pkg::NLANE];
  logic        [63:0]  r11_m1  [hdv_pkg::NLANE];
  logic        [48:0]  r11_m2  [hdv_pkg::NLANE];
  logic                r11_vn  [hdv_pkg::NLANE];
  logic        [113:0] r12_prod[hdv_pkg::NLANE];
  logic                r12_vn  [hdv_pkg::NLANE];
  logic        [121:0] r13_nd  [hdv_pkg::NLANE];
  logic                r13_vn  [hdv_pkg::NLANE];
  hdv_pkg::div_lane_t  r14_lane[hdv_pkg::NLANE];

  // shared stage registers
  logic [47:0]        r0_hm;
  logic               r0_elec;
  logic               r1_weak;
  logic [31:0]        r1_muh;
  logic               r1_elec;
  logic               r2_weak;
  logic               r2_elec;
  logic               r3_elec;
  logic               r4_elec;
  logic [63:0]        r5_d;
  logic signed [65:0] r5_acc;
  logic               r5_elec;
  logic [47:0]        r6_pabs;
  logic               r6_pneg;
  logic [63:0]        r6_d;
  logic               r6_elec;
  logic [63:0]        r7_d;
  logic               r7_elec;
  logic [63:0]        r8_d;
  logic               r8_elec;
  logic [63:0]        r9_d;
  logic               r9_elec;
  logic [63:0]        r10_d;
  logic               r10_elec;
  logic [63:0]        r11_d;
  logic [63:0]        r12_d;
  logic [63:0]        r13_d;
  logic [63:0]        r14_d;

  logic [15:0] hall_c;
  logic [31:0] mob0_c;
  logic [47:0] b2_c;
  logic [47:0] hmr_c;
  logic [65:0] accabs_c;
  logic [65:0] accr_c;
  logic [31:0] mob_c;

  assign hall_c   = mode ? cfg.hhall : cfg.ehall;
  assign mob0_c   = mode ? cfg.hmob : cfg.emob;
  assign b2_c     = 48'(r0_bsq[0]) + 48'(r0_bsq[1]) + 48'(r0_bsq[2]);
  assign hmr_c    = r0_hm + 48'h8000;
  assign accabs_c = r5_acc[65] ? (66'd0 - 66'(r5_acc)) : 66'(r5_acc);
  assign accr_c   = accabs_c + 66'h8000;
  assign mob_c    = r10_elec ? cfg.emob : cfg.hmob;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      r0_hm   <= 48'(hall_c) * 48'(mob0_c);
      r0_elec <= ~mode;
    end
    if (ld[1]) begin
      r1_weak <= b2_c < cfg.thr;
      r1_muh  <= hmr_c[47:16];
      r1_elec <= r0_elec;
    end
    if (ld[2]) begin
      r2_weak <= r1_weak;
      r2_elec <= r1_elec;
    end
    if (ld[3]) begin
      r3_elec <= r2_elec;
    end
    if (ld[4]) begin
      r4_elec <= r3_elec;
    end
    if (ld[5]) begin
      r5_d    <= 64'h1_0000_0000 + 64'(r4_wsq[0]) + 64'(r4_wsq[1]) + 64'(r4_wsq[2]);
      r5_acc  <= 66'(r4_we[0]) + 66'(r4_we[1]) + 66'(r4_we[2]);
      r5_elec <= r4_elec;
    end
    if (ld[6]) begin
      r6_pabs <= accr_c[63:16];
      r6_pneg <= r5_acc[65];
      r6_d    <= r5_d;
      r6_elec <= r5_elec;
    end
    if (ld[7]) begin
      r7_d    <= r6_d;
      r7_elec <= r6_elec;
    end
    if (ld[8]) begin
      r8_d    <= r7_d;
      r8_elec <= r7_elec;
    end
    if (ld[9]) begin
      r9_d    <= r8_d;
      r9_elec <= r8_elec;
    end
    if (ld[10]) begin
      r10_d    <= r9_d;
      r10_elec <= r9_elec;
    end
    if (ld[11]) begin
      r11_d <= r10_d;
    end
    if (ld[12]) begin
      r12_d <= r11_d;
    end
    if (ld[13]) begin
      r13_d <= r12_d;
    end
    if (ld[14]) begin
      r14_d <= r13_d;
    end
  end

  for (genvar g = 0; g < hdv_pkg::NLANE; g++) begin : g_lane
    localparam int J = (g + 1) % hdv_pkg::NLANE;
    localparam int K = (g + 2) % hdv_pkg::NLANE;

    logic [23:0] babs_c;
    logic [55:0] mbr_c;
    logic [30:0] wabs_c;
    logic        wneg_c;
    logic [31:0] w_c;
    logic [81:0] wps_c;
    logic [81:0] nabs_c;

    assign babs_c = b_in[g][23] ? (24'd0 - b_in[g]) : b_in[g];
    // round muH*|B| to Q16.16
    assign mbr_c  = r2_mb[g] + 56'h80_0000;
    assign wabs_c = r2_weak ? 31'd0 : mbr_c[54:24];
    assign wneg_c = r2_bneg[g] ^ r2_elec;
    assign w_c    = wneg_c ? (32'd0 - {1'b0, wabs_c}) : {1'b0, wabs_c};
    assign wps_c  = r8_sneg[g] ? (82'd0 - 82'(r8_wp[g])) : 82'(r8_wp[g]);
    assign nabs_c = r9_n[g][81] ? (82'd0 - r9_n[g]) : r9_n[g];

    always_ff @(posedge clk) begin
      if (ld[0]) begin
        r0_bsq[g]  <= 47'(48'(babs_c) * 48'(babs_c));
        r0_e[g]    <= e_in[g];
        r0_babs[g] <= babs_c;
        r0_bneg[g] <= b_in[g][23];
      end
      if (ld[1]) begin
        r1_e[g]    <= r0_e[g];
        r1_babs[g] <= r0_babs[g];
        r1_bneg[g] <= r0_bneg[g];
      end
      if (ld[2]) begin
        r2_mb[g]   <= 56'(r1_muh) * 56'(r1_babs[g]);
        r2_e[g]    <= r1_e[g];
        r2_bneg[g] <= r1_bneg[g];
      end
      if (ld[3]) begin
        r3_wabs[g] <= wabs_c;
        r3_wneg[g] <= wneg_c;
        r3_w[g]    <= w_c;
        r3_e[g]    <= r2_e[g];
      end
      if (ld[4]) begin
        r4_wsq[g]  <= 62'(r3_wabs[g]) * 62'(r3_wabs[g]);
        r4_we[g]   <= 64'(r3_w[g]) * 64'(r3_e[g]);
        r4_c1[g]   <= 64'(r3_e[J]) * 64'(r3_w[K]);
        r4_c2[g]   <= 64'(r3_e[K]) * 64'(r3_w[J]);
        r4_e[g]    <= r3_e[g];
        r4_wabs[g] <= r3_wabs[g];
        r4_wneg[g] <= r3_wneg[g];
      end
      if (ld[5]) begin
        r5_x[g]    <= $signed({{18{r4_e[g][31]}}, r4_e[g], 16'd0})
                      + 66'(r4_c1[g]) - 66'(r4_c2[g]);
        r5_wabs[g] <= r4_wabs[g];
        r5_wneg[g] <= r4_wneg[g];
      end
      if (ld[6]) begin
        r6_x[g]    <= r5_x[g];
        r6_wabs[g] <= r5_wabs[g];
        r6_wneg[g] <= r5_wneg[g];
      end
      if (ld[7]) begin
        // w*p split in two halves of p
        r7_wplo[g] <= 55'(r6_wabs[g]) * 55'(r6_pabs[23:0]);
        r7_wphi[g] <= 55'(r6_wabs[g]) * 55'(r6_pabs[47:24]);
        r7_sneg[g] <= r6_wneg[g] ^ r6_pneg;
        r7_x[g]    <= r6_x[g];
      end
      if (ld[8]) begin
        r8_wp[g]   <= {r7_wphi[g], 24'd0} + 79'(r7_wplo[g]);
        r8_sneg[g] <= r7_sneg[g];
        r8_x[g]    <= r7_x[g];
      end
      if (ld[9]) begin
        r9_n[g] <= 82'(r8_x[g]) + wps_c;
      end
      if (ld[10]) begin
        r10_nabs[g] <= nabs_c[80:0];
        r10_vn[g]   <= r9_n[g][81] ^ r9_elec;
      end
      if (ld[11]) begin
        r11_m0[g] <= 64'(r10_nabs[g][31:0]) * 64'(mob_c);
        r11_m1[g] <= 64'(r10_nabs[g][63:32]) * 64'(mob_c);
        r11_m2[g] <= 49'(r10_nabs[g][80:64]) * 49'(mob_c);
        r11_vn[g] <= r10_vn[g];
      end
      if (ld[12]) begin
        r12_prod[g] <= 114'(r11_m0[g]) + 114'({r11_m1[g], 32'd0})
                       + 114'({r11_m2[g], 64'd0});
        r12_vn[g]   <= r11_vn[g];
      end
      if (ld[13]) begin
        // dividend with half the divisor added for rounding
        r13_nd[g] <= {r12_prod[g], 8'd0} + 122'(r12_d[63:1]);
        r13_vn[g] <= r12_vn[g];
      end
      if (ld[14]) begin
        r14_lane[g].ovf <= r13_nd[g][121:48] >= 74'(r13_d);
        r14_lane[g].rem <= r13_nd[g][111:48];
        r14_lane[g].nq  <= r13_nd[g][47:0];
        r14_lane[g].vn  <= r13_vn[g];
      end
    end

    assign out_data.lane[g] = r14_lane[g];
  end

  assign out_data.d = r14_d;

endmodule

/* hdl/hdv_div_step.sv */
// ----------------------------------------------------------------------------
// hdv_div_step
// One restoring division step for all three lanes: one quotient bit per lane,
// registered.
// ----------------------------------------------------------------------------
module hdv_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hdv_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hdv_pkg::div_t out_data
);

  logic               ld;
  hdv_pkg::div_lane_t lane_next [hdv_pkg::NLANE];

  assign ld       = ~out_valid | out_ready;
  assign in_ready = ld;

  for (genvar g = 0; g < hdv_pkg::NLANE; g++) begin : g_lane
    logic [64:0] shl;
    logic [64:0] diff;
    logic        ge;

    assign shl  = {in_data.lane[g].rem, in_data.lane[g].nq[47]};
    assign diff = shl - {1'b0, in_data.d};
    assign ge   = shl >= {1'b0, in_data.d};

    assign lane_next[g].rem = ge ? diff[63:0] : shl[63:0];
    // dividend bits shift out at the top, quotient bits fill in below
    assign lane_next[g].nq  = {in_data.lane[g].nq[46:0], ge};
    assign lane_next[g].ovf = in_data.lane[g].ovf;
    assign lane_next[g].vn  = in_data.lane[g].vn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_data.d <= in_data.d;
      for (int i = 0; i < hdv_pkg::NLANE; i++) begin
        out_data.lane[i] <= lane_next[i];
      end
    end
  end

endmodule

/* hdl/hall_drift_velocity_core.sv */
// ----------------------------------------------------------------------------
// hall_drift_velocity_core
// Drift velocity of an electron or hole in crossed E and B fields, Langevin
// form with Hall mobility, Q24.24 result with saturation flag. One beat in and
// one beat out per clock while result_stall is low; path: 15 arithmetic
// stages, 48 long-division stages that each resolve one quotient bit, and
// the output register. A stall only holds full stages, so bubbles close up.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module hall_drift_velocity_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               mode,
  input  logic signed [31:0] efield_x,
  input  logic signed [31:0] efield_y,
  input  logic signed [31:0] efield_z,
  input  logic signed [23:0] bfield_x,
  input  logic signed [23:0] bfield_y,
  input  logic signed [23:0] bfield_z,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [47:0] velocity_x,
  output logic signed [47:0] velocity_y,
  output logic signed [47:0] velocity_z,
  output logic               saturated
);

  hdv_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.emob  <= hdv_pkg::RST_E_MOB;
      cfg.hmob  <= hdv_pkg::RST_H_MOB;
      cfg.ehall <= hdv_pkg::RST_HALL;
      cfg.hhall <= hdv_pkg::RST_HALL;
      cfg.thr   <= hdv_pkg::RST_THRESH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdv_pkg::REG_E_MOB:  cfg.emob  <= cfg_data[31:0];
        hdv_pkg::REG_H_MOB:  cfg.hmob  <= cfg_data[31:0];
        hdv_pkg::REG_E_HALL: cfg.ehall <= cfg_data[15:0];
        hdv_pkg::REG_H_HALL: cfg.hhall <= cfg_data[15:0];
        hdv_pkg::REG_THRESH: cfg.thr   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic          front_ready;
  logic          ld_out;
  hdv_pkg::div_t div_data  [hdv_pkg::DIV_STEPS+1];
  logic          div_valid [hdv_pkg::DIV_STEPS+1];
  logic          div_ready [hdv_pkg::DIV_STEPS+1];

  assign item_stall = ~front_ready;

  hdv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (item_valid),
    .in_ready  (front_ready),
    .mode      (mode),
    .efield_x  (efield_x),
    .efield_y  (efield_y),
    .efield_z  (efield_z),
    .bfield_x  (bfield_x),
    .bfield_y  (bfield_y),
    .bfield_z  (bfield_z),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  for (genvar s = 0; s < hdv_pkg::DIV_STEPS; s++) begin : g_div
    hdv_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[s]),
      .in_ready  (div_ready[s]),
      .in_data   (div_data[s]),
      .out_valid (div_valid[s+1]),
      .out_ready (div_ready[s+1]),
      .out_data  (div_data[s+1])
    );
  end

  assign ld_out = ~result_valid | ~result_stall;
  assign div_ready[hdv_pkg::DIV_STEPS] = ld_out;

  logic        clip_c [hdv_pkg::NLANE];
  logic [47:0] vel_c  [hdv_pkg::NLANE];

  for (genvar g = 0; g < hdv_pkg::NLANE; g++) begin : g_sat
    logic [47:0] q_c;
    logic [47:0] lim_c;
    logic [47:0] mag_c;
    logic        vn_c;

    assign q_c       = div_data[hdv_pkg::DIV_STEPS].lane[g].nq;
    assign vn_c      = div_data[hdv_pkg::DIV_STEPS].lane[g].vn;
    assign lim_c     = vn_c ? hdv_pkg::VEL_NEG_MAG : hdv_pkg::VEL_POS_MAX;
    assign clip_c[g] = div_data[hdv_pkg::DIV_STEPS].lane[g].ovf | (q_c > lim_c);
    assign mag_c     = clip_c[g] ? lim_c : q_c;
    assign vel_c[g]  = vn_c ? (48'd0 - mag_c) : mag_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ld_out) begin
      result_valid <= div_valid[hdv_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      velocity_x <= vel_c[0];
      velocity_y <= vel_c[1];
      velocity_z <= vel_c[2];
      saturated  <= clip_c[0] | clip_c[1] | clip_c[2];
    end
  end

endmodule

/* hdl/hdv_checker.sv */
// ----------------------------------------------------------------------------
// hdv_checker
// Port-level checks for the Hall drift velocity core, bound to the top level.
// ----------------------------------------------------------------------------
module hdv_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [47:0] velocity_x,
  input logic signed [47:0] velocity_y,
  input logic signed [47:0] velocity_z,
  input logic               saturated
);

  // a held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(velocity_x)
      && $stable(velocity_y) && $stable(velocity_z) && $stable(saturated))
    else $error("result beat changed while stalled");

  // input is only back-pressured behind a stalled result
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || !result_stall) |-> !item_stall)
    else $error("input stalled without a stalled result");

  // a clipped beat carries a component at a range bound
  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      velocity_x == hdv_pkg::VEL_POS_MAX || velocity_x == hdv_pkg::VEL_NEG_MAG ||
      velocity_y == hdv_pkg::VEL_POS_MAX || velocity_y == hdv_pkg::VEL_NEG_MAG ||
      velocity_z == hdv_pkg::VEL_POS_MAX || velocity_z == hdv_pkg::VEL_NEG_MAG)
    else $error("saturated flag without a clipped component");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind hall_drift_velocity_core hdv_checker u_hdv_checker (.*);
